FILE: rtl/grm_pkg.sv
// ============================================================================
// grm_pkg
// Shared types, codes and helpers for the greedy rectangle merge block.
// ============================================================================
package grm_pkg;

  localparam int GRID_SIZE_DEF = 16;
  localparam int MAX_GRID      = 64;

  // request kind, carried on s_tuser
  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_FETCH = 1'b1;

  // column store command
  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic clr_vis;
  } grm_cmd_t;

  // one result, in output field widths
  typedef struct packed {
    logic       done_res;
    logic [4:0] rect_height;
    logic [4:0] rect_width;
    logic [3:0] rect_y;
    logic [3:0] rect_x;
  } grm_result_t;

  // index of lowest set bit (0 when none)
  function automatic logic [6:0] ffs(input logic [MAX_GRID:0] v);
    logic [6:0] r;
    r = '0;
    for (int i = MAX_GRID; i >= 0; i--) begin
      if (v[i]) r = 7'(i);
    end
    return r;
  endfunction

endpackage

FILE: rtl/grm_store.sv
// ============================================================================
// grm_store
// Column memory holding solid and visited bits, with per-column valid flags.
// ============================================================================
module grm_store #(
  parameter int GRID_SIZE = grm_pkg::GRID_SIZE_DEF,
  localparam int AW = (GRID_SIZE > 1) ? $clog2(GRID_SIZE) : 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  grm_pkg::grm_cmd_t    cmd,
  input  logic [AW-1:0]        rd_addr,
  input  logic [AW-1:0]        wr_addr,
  input  logic [GRID_SIZE-1:0] wr_sol,
  input  logic [GRID_SIZE-1:0] wr_vis,
  output logic [GRID_SIZE-1:0] rd_sol,
  output logic [GRID_SIZE-1:0] rd_vis
);

  logic [2*GRID_SIZE-1:0] mem [GRID_SIZE];
  logic [2*GRID_SIZE-1:0] rd_q;
  logic [GRID_SIZE-1:0]   sol_ok;
  logic [GRID_SIZE-1:0]   vis_ok;
  logic                   rd_sol_ok;
  logic                   rd_vis_ok;

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wr_addr] <= {wr_vis, wr_sol};
    end
    if (cmd.rd_en) begin
      rd_q      <= mem[rd_addr];
      rd_sol_ok <= sol_ok[rd_addr];
      rd_vis_ok <= vis_ok[rd_addr];
    end
  end

  // invalid columns read as zero; a load drops every visited column
  always_ff @(posedge clk) begin
    if (rst) begin
      sol_ok <= '0;
      vis_ok <= '0;
    end else begin
      if (cmd.clr_vis) vis_ok <= '0;
      if (cmd.wr_en) begin
        sol_ok[wr_addr] <= 1'b1;
        if (!cmd.clr_vis) vis_ok[wr_addr] <= 1'b1;
      end
    end
  end

  assign rd_sol = rd_q[GRID_SIZE-1:0]           & {GRID_SIZE{rd_sol_ok}};
  assign rd_vis = rd_q[2*GRID_SIZE-1:GRID_SIZE] & {GRID_SIZE{rd_vis_ok}};

endmodule

FILE: rtl/grm_ctrl.sv
// ============================================================================
// grm_ctrl
// Scan, widen, heighten and mark sequencer, at most one column read per cycle.
// ============================================================================
module grm_ctrl #(
  parameter int GRID_SIZE = grm_pkg::GRID_SIZE_DEF,
  localparam int AW = (GRID_SIZE > 1) ? $clog2(GRID_SIZE) : 1,
  localparam int XW = $clog2(GRID_SIZE + 1)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_func,
  input  logic [3:0]            in_index,
  input  logic [15:0]           in_bits,
  output logic                  res_valid,
  input  logic                  res_ready,
  output grm_pkg::grm_result_t  res,
  output grm_pkg::grm_cmd_t     cmd,
  output logic [AW-1:0]         rd_addr,
  output logic [AW-1:0]         wr_addr,
  output logic [GRID_SIZE-1:0]  wr_sol,
  output logic [GRID_SIZE-1:0]  wr_vis,
  input  logic [GRID_SIZE-1:0]  rd_sol,
  input  logic [GRID_SIZE-1:0]  rd_vis
);

  localparam logic [XW-1:0] GX   = XW'(GRID_SIZE);
  localparam logic [AW-1:0] TOPY = AW'(GRID_SIZE - 1);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_SCAN   = 6'b000010,
    S_WIDEN  = 6'b000100,
    S_HEIGHT = 6'b001000,
    S_MARK   = 6'b010000,
    S_OUT    = 6'b100000
  } state_t;

  state_t               state, state_next;
  logic [XW-1:0]        sx, sx_next;
  logic [AW-1:0]        sy, sy_next;
  logic [AW-1:0]        rx, rx_next;
  logic [AW-1:0]        ry, ry_next;
  logic [XW-1:0]        rw, rw_next;
  logic [XW-1:0]        rh, rh_next;
  logic [AW-1:0]        cx, cx_next;
  logic [AW-1:0]        lastx, lastx_next;
  logic [GRID_SIZE-1:0] span, span_next;
  logic [GRID_SIZE-1:0] mark, mark_next;
  logic                 done_q, done_next;

  logic [GRID_SIZE-1:0] free_col;
  logic [GRID_SIZE-1:0] cand;
  logic [GRID_SIZE:0]   run_inv;
  logic [XW-1:0]        h_calc;
  logic [XW-1:0]        sx_inc;
  logic [XW-1:0]        cx_inc;
  logic                 in_req;

  assign free_col = rd_sol & ~rd_vis;
  assign cand     = free_col & ({GRID_SIZE{1'b1}} << sy);
  assign run_inv  = {1'b1, ~(span >> ry)};
  assign h_calc   = XW'(grm_pkg::ffs((grm_pkg::MAX_GRID + 1)'(run_inv)));
  assign sx_inc   = sx + XW'(1);
  assign cx_inc   = XW'(cx) + XW'(1);
  assign in_ready = (state == S_IDLE);
  assign in_req   = in_valid && in_ready;

  always_comb begin
    state_next = state;
    sx_next    = sx;
    sy_next    = sy;
    rx_next    = rx;
    ry_next    = ry;
    rw_next    = rw;
    rh_next    = rh;
    cx_next    = cx;
    lastx_next = lastx;
    span_next  = span;
    mark_next  = mark;
    done_next  = done_q;
    cmd        = '0;
    rd_addr    = cx;
    wr_addr    = cx;
    wr_sol     = rd_sol;
    wr_vis     = rd_vis | mark;
    res_valid  = 1'b0;

    case (state)
      S_IDLE: begin
        if (in_req) begin
          if (in_func == grm_pkg::FUNC_LOAD) begin
            cmd.clr_vis = 1'b1;
            cmd.wr_en   = (7'(in_index) < 7'(GRID_SIZE));
            wr_addr     = AW'(in_index);
            wr_sol      = GRID_SIZE'(in_bits);
            wr_vis      = '0;
            sx_next     = '0;
            sy_next     = '0;
          end else if (sx == GX) begin
            done_next  = 1'b1;
            state_next = S_OUT;
          end else begin
            cmd.rd_en  = 1'b1;
            rd_addr    = AW'(sx);
            state_next = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (cand != '0) begin
          rx_next   = AW'(sx);
          ry_next   = AW'(grm_pkg::ffs((grm_pkg::MAX_GRID + 1)'(cand)));
          rw_next   = XW'(1);
          span_next = free_col;
          if (sx_inc < GX) begin
            cmd.rd_en  = 1'b1;
            rd_addr    = AW'(sx_inc);
            cx_next    = AW'(sx_inc);
            state_next = S_WIDEN;
          end else begin
            state_next = S_HEIGHT;
          end
        end else begin
          sx_next = sx_inc;
          sy_next = '0;
          if (sx_inc == GX) begin
            done_next  = 1'b1;
            state_next = S_OUT;
          end else begin
            cmd.rd_en = 1'b1;
            rd_addr   = AW'(sx_inc);
          end
        end
      end
      S_WIDEN: begin
        if (free_col[ry]) begin
          span_next = span & free_col;
          rw_next   = rw + XW'(1);
          if (cx_inc < GX) begin
            cmd.rd_en = 1'b1;
            rd_addr   = AW'(cx_inc);
            cx_next   = AW'(cx_inc);
          end else begin
            state_next = S_HEIGHT;
          end
        end else begin
          state_next = S_HEIGHT;
        end
      end
      S_HEIGHT: begin
        rh_next    = h_calc;
        mark_next  = (~({GRID_SIZE{1'b1}} << h_calc)) << ry;
        lastx_next = AW'(XW'(rx) + rw - XW'(1));
        // scan resumes at the cell after the corner
        if (ry == TOPY) begin
          sx_next = XW'(rx) + XW'(1);
          sy_next = '0;
        end else begin
          sy_next = ry + AW'(1);
        end
        cmd.rd_en  = 1'b1;
        rd_addr    = rx;
        cx_next    = rx;
        done_next  = 1'b0;
        state_next = S_MARK;
      end
      S_MARK: begin
        cmd.wr_en = 1'b1;
        if (cx != lastx) begin
          cmd.rd_en = 1'b1;
          rd_addr   = AW'(cx_inc);
          cx_next   = AW'(cx_inc);
        end else begin
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        res_valid = 1'b1;
        if (res_ready) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (done_q) begin
      res          = '0;
      res.done_res = 1'b1;
    end else begin
      res.done_res    = 1'b0;
      res.rect_x      = 4'(rx);
      res.rect_y      = 4'(ry);
      res.rect_width  = 5'(rw);
      res.rect_height = 5'(rh);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      sx    <= '0;
      sy    <= '0;
    end else begin
      state <= state_next;
      sx    <= sx_next;
      sy    <= sy_next;
    end
  end

  always_ff @(posedge clk) begin
    rx     <= rx_next;
    ry     <= ry_next;
    rw     <= rw_next;
    rh     <= rh_next;
    cx     <= cx_next;
    lastx  <= lastx_next;
    span   <= span_next;
    mark   <= mark_next;
    done_q <= done_next;
  end

endmodule

FILE: rtl/greedy_rectangle_merge.sv
// ============================================================================
// greedy_rectangle_merge
// Greedy rectangle cover of a square occupancy grid, fetched one per request.
// ============================================================================
//
//  channel  dir  handshake          tdata                         tuser
//  -------  ---  -----------------  ----------------------------  --------
//  s_*      in   s_tvalid/s_tready  column_index, column_bits     func
//  m_*      out  m_tvalid/m_tready  rect_x, rect_y, width, height done_res
//
//  Load request: no result.
//  Fetch request: scan, widen, heighten and mark steps, then the result;
//    a fetch at end of scan goes straight to the result.
//    The single column memory sets the pace: one column read a cycle at most.
//  Reset: synchronous; per-column valid flags make the grid read as empty
//    at once, no clearing pass.
//  Stalls: a held result sits in the output register; the next request is
//    taken meanwhile, and its own result waits until the register frees.
//
module greedy_rectangle_merge #(
  parameter int GRID_SIZE = grm_pkg::GRID_SIZE_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // [3:0] column_index, [19:4] column_bits, rest zero
  input  logic        s_tuser,   // [0] func
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [3:0] rect_x, [7:4] rect_y, [12:8] rect_width,
                                 // [17:13] rect_height, rest zero
  output logic        m_tuser    // [0] done_res
);

  localparam int AW = (GRID_SIZE > 1) ? $clog2(GRID_SIZE) : 1;

  grm_pkg::grm_cmd_t    cmd;
  grm_pkg::grm_result_t res;
  grm_pkg::grm_result_t out_q;
  logic                 res_valid;
  logic                 res_ready;
  logic [AW-1:0]        rd_addr;
  logic [AW-1:0]        wr_addr;
  logic [GRID_SIZE-1:0] wr_sol;
  logic [GRID_SIZE-1:0] wr_vis;
  logic [GRID_SIZE-1:0] rd_sol;
  logic [GRID_SIZE-1:0] rd_vis;

  grm_ctrl #(.GRID_SIZE(GRID_SIZE)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_func   (s_tuser),
    .in_index  (s_tdata[3:0]),
    .in_bits   (s_tdata[19:4]),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .cmd       (cmd),
    .rd_addr   (rd_addr),
    .wr_addr   (wr_addr),
    .wr_sol    (wr_sol),
    .wr_vis    (wr_vis),
    .rd_sol    (rd_sol),
    .rd_vis    (rd_vis)
  );

  grm_store #(.GRID_SIZE(GRID_SIZE)) u_store (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .rd_addr (rd_addr),
    .wr_addr (wr_addr),
    .wr_sol  (wr_sol),
    .wr_vis  (wr_vis),
    .rd_sol  (rd_sol),
    .rd_vis  (rd_vis)
  );

  // output register: frees when empty or taken this cycle
  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid && res_ready) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) out_q <= res;
  end

  assign m_tdata = {6'b0, out_q.rect_height, out_q.rect_width, out_q.rect_y, out_q.rect_x};
  assign m_tuser = out_q.done_res;

endmodule

FILE: rtl/grm_checker.sv
// ============================================================================
// grm_checker
// Port-level checks on the greedy rectangle merge block.
// ============================================================================
module grm_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata,
  input logic        m_tuser
);

  // nothing shows right after reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // held result stays put
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

  // done result carries no rectangle
  a_done_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata == 24'd0)
    else $error("done result with nonzero rectangle");

  // no request yields its result in the very next cycle
  a_no_instant: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && !m_tvalid |=> !m_tvalid)
    else $error("result appeared too early");

endmodule

bind greedy_rectangle_merge grm_checker u_grm_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

FILE: verif/greedy_rectangle_merge_test.sv
// ============================================================================
// greedy_rectangle_merge_test
// Self-checking bench: loads occupancy grids, fetches rectangles until done,
// and checks every result against a cycle-free model of the greedy cover.
// ============================================================================
`timescale 1ns / 100ps

// Tracks the grid as the block should see it and predicts each fetch result.
class rect_cover_tracker;
  localparam int GRID = grm_pkg::GRID_SIZE_DEF;

  logic [15:0]          solid [GRID];
  logic [15:0]          covered [GRID];
  int unsigned          scan_pos;
  grm_pkg::grm_result_t rects_due [$];
  bit                   last_done;
  int unsigned          errors, loads, fetches, dones, rects, widest, tallest;

  function new();
    foreach (solid[i]) begin
      solid[i]   = '0;
      covered[i] = '0;
    end
    scan_pos  = 0;
    last_done = 1'b0;
    errors    = 0;
    loads     = 0;
    fetches   = 0;
    dones     = 0;
    rects     = 0;
    widest    = 0;
    tallest   = 0;
  endfunction

  function bit is_open(int x, int y);
    return solid[x][y] && !covered[x][y];
  endfunction

  function int unsigned pending();
    return rects_due.size();
  endfunction

  // Called for each accepted request; a fetch queues its expected rectangle.
  function void take_request(logic func, logic [3:0] col, logic [15:0] bits);
    grm_pkg::grm_result_t r;
    int x, y, w, h;
    bit ok;
    if (func == grm_pkg::FUNC_LOAD) begin
      solid[col] = bits;
      foreach (covered[i]) covered[i] = '0;
      scan_pos = 0;
      loads++;
      return;
    end
    fetches++;
    while (scan_pos < GRID * GRID && !is_open(scan_pos / GRID, scan_pos % GRID))
      scan_pos++;
    r = '0;
    if (scan_pos >= GRID * GRID) begin
      scan_pos    = GRID * GRID;
      r.done_res  = 1'b1;
      last_done   = 1'b1;
      dones++;
    end else begin
      x = scan_pos / GRID;
      y = scan_pos % GRID;
      w = 1;
      while (x + w < GRID && is_open(x + w, y)) w++;
      h  = 1;
      ok = 1'b1;
      while (ok && y + h < GRID) begin
        for (int i = 0; i < w; i++)
          if (!is_open(x + i, y + h)) ok = 1'b0;
        if (ok) h++;
      end
      for (int i = 0; i < w; i++)
        for (int j = 0; j < h; j++)
          covered[x + i][y + j] = 1'b1;
      scan_pos++;
      r.rect_x      = 4'(x);
      r.rect_y      = 4'(y);
      r.rect_width  = 5'(w);
      r.rect_height = 5'(h);
      last_done     = 1'b0;
      rects++;
      if (w > widest) widest = w;
      if (h > tallest) tallest = h;
    end
    rects_due.push_back(r);
  endfunction

  function void compare(string field, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", field, want, got);
      errors++;
    end
  endfunction

  // Called for each accepted result; checks it against the oldest expectation.
  function void match_rect(logic [23:0] data, logic flag);
    grm_pkg::grm_result_t want, got;
    got = {flag, data[17:0]};
    if (rects_due.size() == 0) begin
      $error("unexpected result: x=%0d y=%0d w=%0d h=%0d done=%0d",
             got.rect_x, got.rect_y, got.rect_width, got.rect_height, got.done_res);
      errors++;
      return;
    end
    want = rects_due.pop_front();
    compare("rect_x", want.rect_x, got.rect_x);
    compare("rect_y", want.rect_y, got.rect_y);
    compare("rect_width", want.rect_width, got.rect_width);
    compare("rect_height", want.rect_height, got.rect_height);
    compare("done_res", want.done_res, got.done_res);
    compare("tdata padding", 0, data[23:18]);
  endfunction
endclass

module greedy_rectangle_merge_test;

  localparam int GRID         = grm_pkg::GRID_SIZE_DEF;
  localparam int TOTAL_ITEMS  = 800;
  localparam int CALM_FROM    = 680;      // no idling on either side past this
  localparam int DRAIN_CYCLES = 3 * GRID + 20;
  localparam int CYCLE_LIMIT  = 400_000;

  typedef enum int {
    PLAN_EMPTY, PLAN_FULL, PLAN_RANDOM, PLAN_DENSE, PLAN_SPARSE, PLAN_BLOCKS, PLAN_BARS
  } plan_style_t;

  logic        clk;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata  = '0;
  logic        s_tuser  = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;
  logic        m_tuser;

  rect_cover_tracker sb = new();

  int unsigned sent        = 0;
  bit          calm        = 1'b0;
  int unsigned gap_odds    = 0;   // 0: sender never idles, else 1 in gap_odds
  int unsigned stall_odds  = 0;   // same for the result side
  int unsigned stall_left  = 0;
  int unsigned cycle_count = 0;
  logic [15:0] plan [GRID];

  greedy_rectangle_merge #(.GRID_SIZE(GRID)) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Watchdog: the slowest legal run is far below this.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Result side: random stall bursts, none once the run turns calm.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      m_tready <= 1'b0;
      stall_left--;
    end else if (!calm && stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
      m_tready   <= 1'b0;
      stall_left = $urandom_range(1, 12) - 1;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Result monitor; values sampled at the edge are the pre-edge ones.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.match_rect(m_tdata, m_tuser);
  end

  // One request on the slave side. s_tvalid stays high between back-to-back
  // requests and only drops for an idle burst, so it never gets two updates
  // in one step.
  task automatic push_request(input logic func, input logic [3:0] col,
                              input logic [15:0] bits);
    if (!calm && gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= func;
    s_tdata  <= {4'b0, bits, col};
    do @(posedge clk); while (!s_tready);
    sb.take_request(func, col, bits);
    sent++;
    if (sent >= CALM_FROM) calm = 1'b1;
  endtask

  // Fetch with don't-care column fields; random so those bits toggle too.
  task automatic fetch_rect();
    push_request(grm_pkg::FUNC_FETCH, 4'($urandom), 16'($urandom));
  endtask

  task automatic load_column(input int col, input logic [15:0] bits);
    push_request(grm_pkg::FUNC_LOAD, 4'(col), bits);
  endtask

  // Builds a target grid in plan[]; blocks and bars give large merges, the
  // random styles give many small rectangles.
  function automatic void build_plan(plan_style_t style);
    int n, x0, x1, y0, y1;
    logic [15:0] bar;
    bar = 16'($urandom);
    foreach (plan[i]) begin
      case (style)
        PLAN_EMPTY:  plan[i] = '0;
        PLAN_FULL:   plan[i] = '1;
        PLAN_RANDOM: plan[i] = 16'($urandom);
        PLAN_DENSE:  plan[i] = 16'($urandom | $urandom);
        PLAN_SPARSE: plan[i] = 16'($urandom & $urandom & $urandom);
        PLAN_BARS:   plan[i] = ($urandom_range(0, 5) == 0) ? 16'($urandom) : bar;
        default:     plan[i] = '0;
      endcase
    end
    if (style == PLAN_BLOCKS) begin
      n = $urandom_range(1, 6);
      repeat (n) begin
        x0 = $urandom_range(0, GRID - 1);
        x1 = $urandom_range(x0, GRID - 1);
        y0 = $urandom_range(0, GRID - 1);
        y1 = $urandom_range(y0, GRID - 1);
        for (int x = x0; x <= x1; x++)
          for (int y = y0; y <= y1; y++)
            plan[x][y] = 1'b1;
      end
    end
  endfunction

  // Well-formed sequence: load a grid (columns in shuffled order, sometimes
  // only part of it), then fetch until done and a little past it. Now and
  // then a load lands mid-scan and restarts the cover.
  task automatic run_grid_sequence();
    int order [GRID];
    int j, tmp, n_load, guard;
    plan_style_t style;
    case ($urandom_range(0, 9))
      0:       style = PLAN_EMPTY;
      1:       style = PLAN_FULL;
      2:       style = PLAN_RANDOM;
      3:       style = PLAN_DENSE;
      4:       style = PLAN_SPARSE;
      5, 6:    style = PLAN_BARS;
      default: style = PLAN_BLOCKS;
    endcase
    build_plan(style);
    foreach (order[i]) order[i] = i;
    for (int i = GRID - 1; i > 0; i--) begin
      j        = $urandom_range(0, i);
      tmp      = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    n_load = ($urandom_range(0, 4) == 0) ? $urandom_range(1, GRID - 1) : GRID;
    for (int i = 0; i < n_load; i++) load_column(order[i], plan[order[i]]);
    guard = 0;
    do begin
      fetch_rect();
      guard++;
      if ($urandom_range(0, 39) == 0) begin
        j = $urandom_range(0, GRID - 1);
        load_column(j, ($urandom_range(0, 1) == 0) ? plan[j] : 16'($urandom));
      end
    end while (!sb.last_done && guard < 300);
    repeat ($urandom_range(0, 2)) fetch_rect();
  endtask

  // Noise: loads and fetches in any order with arbitrary content.
  task automatic run_noise();
    repeat ($urandom_range(8, 20)) begin
      push_request(1'($urandom), 4'($urandom), 16'($urandom));
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed: done on an empty grid (twice, the scan stays at its end),
    // single full column, corner cells at column 15, then the full grid for
    // the largest width and height.
    fetch_rect();
    fetch_rect();
    load_column(0, 16'hFFFF);
    load_column(GRID - 1, 16'h8001);
    fetch_rect();
    fetch_rect();
    fetch_rect();
    fetch_rect();
    for (int x = 1; x < GRID; x++) load_column(x, 16'hFFFF);
    fetch_rect();
    fetch_rect();

    // Random part: mostly well-formed grids, some noise, with idling odds
    // picked per chunk so some chunks run without any idling.
    while (sent < TOTAL_ITEMS) begin
      gap_odds   = $urandom_range(0, 3) * 3;
      stall_odds = $urandom_range(0, 3) * 3;
      if ($urandom_range(0, 7) == 0) run_noise();
      else run_grid_sequence();
    end
    s_tvalid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d grid loads and %0d fetches: %0d rectangles, %0d done replies",
             sb.loads, sb.fetches, sb.rects, sb.dones);
    $display("widest rectangle %0d cells, tallest %0d cells, %0d mismatches",
             sb.widest, sb.tallest, sb.errors);
    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
